/* sv/amc_pkg.sv */
// shared types, constants and helper functions for the anammox rate cell
package amc_pkg;

    // value format
    localparam int W  = 32;
    localparam int F  = 16;
    localparam int QW = F + 1;

    // fixed point constants
    localparam logic [W-1:0] ONE    = W'(64'd1 << F);
    localparam logic [F-1:0] INV114 = F'((100 * (64'd1 << F) + 57) / 114);

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAX_GROWTH  = 3'd0,
        CFG_NH4_AFFIN   = 3'd1,
        CFG_O2_AFFIN    = 3'd2,
        CFG_NO2_AFFIN   = 3'd3,
        CFG_INV_YIELD   = 3'd4,
        CFG_MAINT       = 3'd5,
        CFG_DECAY       = 3'd6
    } cfg_idx_t;

    // input word
    typedef struct packed {
        logic [W-1:0] nh4_concentration;
        logic [W-1:0] no2_concentration;
        logic [W-1:0] o2_concentration;
        logic [W-1:0] biomass_density;
        logic         ghost_cell;
        logic         last_cell;
    } in_t;

    // result word
    typedef struct packed {
        logic signed [W-1:0] nh4_reaction_change;
        logic signed [W-1:0] no2_reaction_change;
        logic signed [W-1:0] no3_reaction_change;
        logic signed [W-1:0] n2_reaction_change;
        logic signed [W-1:0] net_growth_rate;
        logic                last_cell_out;
    } out_t;

    // fields carried beside the dividers
    typedef struct packed {
        logic [W-1:0] dens;
        logic         ghost;
        logic         last;
        logic         z_nh4;
        logic         z_no2;
        logic         z_o;
    } sb_t;

    // negate a magnitude, clamping at the most negative value
    function automatic logic signed [W-1:0] sat_neg(input logic [2*W:0] mag);
        logic signed [W-1:0] res;
        if (mag > (2*W+1)'(64'd1 << (W-1)))
            res = {1'b1, {(W-1){1'b0}}};
        else
            res = W'(0) - mag[W-1:0];
        return res;
    endfunction

    // clamp a magnitude at the most positive value
    function automatic logic signed [W-1:0] sat_pos(input logic [2*W:0] mag);
        logic signed [W-1:0] res;
        if (mag > (2*W+1)'((64'd1 << (W-1)) - 1))
            res = {1'b0, {(W-1){1'b1}}};
        else
            res = mag[W-1:0];
        return res;
    endfunction

endpackage

/* sv/amc_div_pipe.sv */
// pipelined restoring divider for one monod term, one quotient bit per stage
module amc_div_pipe (
    input  logic                     clk,
    input  logic                     en,
    input  logic [amc_pkg::W-1:0]    num,
    input  logic [amc_pkg::W:0]      den,
    output logic [amc_pkg::QW-1:0]   quo
);

    logic [amc_pkg::W:0]    rem_reg [0:amc_pkg::QW-1];
    logic [amc_pkg::W:0]    den_reg [0:amc_pkg::QW-1];
    logic [amc_pkg::QW-1:0] quo_reg [0:amc_pkg::QW-1];

    // first stage: numerator never exceeds denominator, so only the top bit
    logic                   ge0;
    logic [amc_pkg::W:0]    num_ext;

    assign num_ext = {1'b0, num};
    assign ge0     = num_ext >= den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ge0 ? num_ext - den : num_ext;
            den_reg[0] <= den;
            quo_reg[0] <= {ge0, {(amc_pkg::QW-1){1'b0}}};
        end
    end

    // remaining stages: shift, compare, subtract
    for (genvar k = 1; k < amc_pkg::QW; k++)
    begin : g_step
        logic [amc_pkg::W+1:0]  trial;
        logic                   ge;
        logic [amc_pkg::W+1:0]  diff;
        logic [amc_pkg::QW-1:0] q_next;

        assign trial = {rem_reg[k-1], 1'b0};
        assign ge    = trial >= {1'b0, den_reg[k-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_comb
        begin
            q_next = quo_reg[k-1];
            q_next[amc_pkg::QW-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[amc_pkg::W:0] : trial[amc_pkg::W:0];
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= q_next;
            end
        end
    end

    assign quo = quo_reg[amc_pkg::QW-1];

endmodule

/* sv/anammox_monod_rate_cell_top.sv */
// top level of the anammox rate cell: config registers, monod dividers and rate datapath
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  cell     | cell_valid, cell_stall, cell_word (in_t)       | in
//  result   | result_valid, result_stall, result (out_t)     | out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// one word enters per cycle unless the result side stalls; the pipeline is an input stage, 17 divider
// stages set by the 17 quotient bits, six multiply/sum stages and an output register
// the whole pipeline advances together when the output register is free
// a stall on the result side freezes every stage; nothing is dropped
// reset clears valid bits and loads config defaults (inverse yield 1.0)
module anammox_monod_rate_cell_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cell_valid,
    output logic                    cell_stall,
    input  amc_pkg::in_t            cell_word,
    output logic                    result_valid,
    input  logic                    result_stall,
    output amc_pkg::out_t           result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [amc_pkg::W-1:0]   cfg_data
);

    localparam int W  = amc_pkg::W;
    localparam int F  = amc_pkg::F;
    localparam int QW = amc_pkg::QW;

    // config registers
    logic [W-1:0] mu_reg, ks_reg, ko_reg, kn_reg, iy_reg, maint_reg, decay_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg    <= '0;
            ks_reg    <= '0;
            ko_reg    <= '0;
            kn_reg    <= '0;
            iy_reg    <= amc_pkg::ONE;
            maint_reg <= '0;
            decay_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                amc_pkg::CFG_MAX_GROWTH: mu_reg    <= cfg_data;
                amc_pkg::CFG_NH4_AFFIN:  ks_reg    <= cfg_data;
                amc_pkg::CFG_O2_AFFIN:   ko_reg    <= cfg_data;
                amc_pkg::CFG_NO2_AFFIN:  kn_reg    <= cfg_data;
                amc_pkg::CFG_INV_YIELD:  iy_reg    <= cfg_data;
                amc_pkg::CFG_MAINT:      maint_reg <= cfg_data;
                amc_pkg::CFG_DECAY:      decay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance
    logic adv;
    assign adv        = !result_valid || !result_stall;
    assign cell_stall = !adv;

    // input stage: denominators and zero flags
    logic          s0_valid_reg;
    logic [W-1:0]  s0_nh4_reg, s0_no2_reg, s0_o2_reg;
    logic [W:0]    s0_dnh4_reg, s0_dno2_reg, s0_do_reg;
    amc_pkg::sb_t  s0_sb_reg;

    logic [W:0]    dnh4_next, dno2_next, do_next;
    assign dnh4_next = {1'b0, cell_word.nh4_concentration} + {1'b0, ks_reg};
    assign dno2_next = {1'b0, cell_word.no2_concentration} + {1'b0, kn_reg};
    assign do_next   = {1'b0, cell_word.o2_concentration} + {1'b0, ko_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_nh4_reg      <= cell_word.nh4_concentration;
            s0_no2_reg      <= cell_word.no2_concentration;
            s0_o2_reg       <= cell_word.o2_concentration;
            s0_dnh4_reg     <= dnh4_next;
            s0_dno2_reg     <= dno2_next;
            s0_do_reg       <= do_next;
            s0_sb_reg.dens  <= cell_word.biomass_density;
            s0_sb_reg.ghost <= cell_word.ghost_cell;
            s0_sb_reg.last  <= cell_word.last_cell;
            s0_sb_reg.z_nh4 <= dnh4_next == '0;
            s0_sb_reg.z_no2 <= dno2_next == '0;
            s0_sb_reg.z_o   <= do_next == '0;
        end
    end

    // monod and inhibition dividers
    logic [QW-1:0] q_nh4, q_no2, q_inh, q_o2;

    amc_div_pipe u_div_nh4 (.clk(clk), .en(adv), .num(s0_nh4_reg), .den(s0_dnh4_reg), .quo(q_nh4));
    amc_div_pipe u_div_no2 (.clk(clk), .en(adv), .num(s0_no2_reg), .den(s0_dno2_reg), .quo(q_no2));
    amc_div_pipe u_div_inh (.clk(clk), .en(adv), .num(ko_reg),     .den(s0_do_reg),   .quo(q_inh));
    amc_div_pipe u_div_o2  (.clk(clk), .en(adv), .num(s0_o2_reg),  .den(s0_do_reg),   .quo(q_o2));

    // side fields delayed alongside the dividers
    amc_pkg::sb_t  dsb_reg [0:QW-1];
    logic [QW-1:0] dv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dsb_reg[0] <= s0_sb_reg;
            for (int k = 1; k < QW; k++)
            begin
                dsb_reg[k] <= dsb_reg[k-1];
            end
        end
    end

    // valid bits of all stages
    logic r1_valid_reg, r2_valid_reg, r3_valid_reg, r4_valid_reg, r5_valid_reg, r6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            dv_reg       <= '0;
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
            r5_valid_reg <= 1'b0;
            r6_valid_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= cell_valid;
            dv_reg       <= {dv_reg[QW-2:0], s0_valid_reg};
            r1_valid_reg <= dv_reg[QW-1];
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            r4_valid_reg <= r3_valid_reg;
            r5_valid_reg <= r4_valid_reg;
            r6_valid_reg <= r5_valid_reg;
            result_valid <= r6_valid_reg;
        end
    end

    // resolve zero denominators
    amc_pkg::sb_t  dsb;
    logic [QW-1:0] t_nh4, t_no2, t_inh, t_o2;

    assign dsb   = dsb_reg[QW-1];
    assign t_nh4 = dsb.z_nh4 ? '0 : q_nh4;
    assign t_no2 = dsb.z_no2 ? '0 : q_no2;
    assign t_inh = dsb.z_o ? QW'(amc_pkg::ONE) : q_inh;
    assign t_o2  = dsb.z_o ? '0 : q_o2;

    // r1: mu times ammonium term, maintenance times oxygen term
    logic [W-1:0]    r1_rate_reg, r1_lossm_reg;
    logic [QW-1:0]   r1_tno2_reg, r1_tinh_reg;
    amc_pkg::sb_t    r1_sb_reg;
    logic [W+QW-1:0] p_rate1, p_lossm;

    assign p_rate1 = (W+QW)'(mu_reg) * (W+QW)'(t_nh4);
    assign p_lossm = (W+QW)'(maint_reg) * (W+QW)'(t_o2);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_rate_reg  <= p_rate1[F +: W];
            r1_lossm_reg <= p_lossm[F +: W];
            r1_tno2_reg  <= t_no2;
            r1_tinh_reg  <= t_inh;
            r1_sb_reg    <= dsb;
        end
    end

    // r2: times nitrite term, total loss
    logic [W-1:0]    r2_rate_reg;
    logic [W:0]      r2_loss_reg;
    logic [QW-1:0]   r2_tinh_reg;
    amc_pkg::sb_t    r2_sb_reg;
    logic [W+QW-1:0] p_rate2;

    assign p_rate2 = (W+QW)'(r1_rate_reg) * (W+QW)'(r1_tno2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_rate_reg <= p_rate2[F +: W];
            r2_loss_reg <= {1'b0, r1_lossm_reg} + {1'b0, decay_reg};
            r2_tinh_reg <= r1_tinh_reg;
            r2_sb_reg   <= r1_sb_reg;
        end
    end

    // r3: times inhibition term
    logic [W-1:0]    r3_rate_reg;
    logic [W:0]      r3_loss_reg;
    amc_pkg::sb_t    r3_sb_reg;
    logic [W+QW-1:0] p_rate3;

    assign p_rate3 = (W+QW)'(r2_rate_reg) * (W+QW)'(r2_tinh_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r3_rate_reg <= p_rate3[F +: W];
            r3_loss_reg <= r2_loss_reg;
            r3_sb_reg   <= r2_sb_reg;
        end
    end

    // r4: rate times density, clamped net growth
    logic [2*W-1:0]        r4_prod_reg;
    logic signed [W-1:0]   r4_net_reg;
    logic                  r4_ghost_reg, r4_last_reg;
    logic signed [W+2:0]   net_diff;
    logic signed [W-1:0]  net_next;

    assign net_diff = $signed({2'b0, r3_rate_reg}) - $signed({2'b0, r3_loss_reg});

    always_comb
    begin
        if (net_diff > $signed((W+3)'((64'd1 << (W-1)) - 1)))
            net_next = {1'b0, {(W-1){1'b1}}};
        else if (net_diff < -$signed((W+3)'(64'd1 << (W-1))))
            net_next = {1'b1, {(W-1){1'b0}}};
        else
            net_next = net_diff[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r4_prod_reg  <= (2*W)'(r3_rate_reg) * (2*W)'(r3_sb_reg.dens);
            r4_net_reg   <= net_next;
            r4_ghost_reg <= r3_sb_reg.ghost;
            r4_last_reg  <= r3_sb_reg.last;
        end
    end

    // r5: partial products of yield and nitrate coefficients
    logic [2*W-1:0]      r5_iy_lo_reg, r5_iy_hi_reg;
    logic [W+F-1:0]      r5_c_lo_reg, r5_c_hi_reg;
    logic signed [W-1:0] r5_net_reg;
    logic                r5_ghost_reg, r5_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r5_iy_lo_reg <= (2*W)'(iy_reg) * (2*W)'(r4_prod_reg[W-1:0]);
            r5_iy_hi_reg <= (2*W)'(iy_reg) * (2*W)'(r4_prod_reg[2*W-1:W]);
            r5_c_lo_reg  <= (W+F)'(amc_pkg::INV114) * (W+F)'(r4_prod_reg[W-1:0]);
            r5_c_hi_reg  <= (W+F)'(amc_pkg::INV114) * (W+F)'(r4_prod_reg[2*W-1:W]);
            r5_net_reg   <= r4_net_reg;
            r5_ghost_reg <= r4_ghost_reg;
            r5_last_reg  <= r4_last_reg;
        end
    end

    // r6: full products
    logic [3*W-1:0]      r6_a_reg;
    logic [2*W+F-1:0]    r6_b_reg;
    logic signed [W-1:0] r6_net_reg;
    logic                r6_ghost_reg, r6_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r6_a_reg     <= {r5_iy_hi_reg, {W{1'b0}}} + (3*W)'(r5_iy_lo_reg);
            r6_b_reg     <= {r5_c_hi_reg, {W{1'b0}}} + (2*W+F)'(r5_c_lo_reg);
            r6_net_reg   <= r5_net_reg;
            r6_ghost_reg <= r5_ghost_reg;
            r6_last_reg  <= r5_last_reg;
        end
    end

    // output: scale, saturate and blank ghost cells
    logic [3*W:0] ab_sum;
    logic [2*W:0] mag_nh4, mag_no2, mag_no3, mag_n2;

    assign ab_sum  = (3*W+1)'(r6_a_reg) + (3*W+1)'(r6_b_reg);
    assign mag_nh4 = (2*W+1)'(r6_a_reg[3*W-1:W]);
    assign mag_no2 = ab_sum[3*W:W];
    assign mag_no3 = (2*W+1)'(r6_b_reg[2*W+F-1:W]);
    assign mag_n2  = r6_a_reg[3*W-1:W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result.nh4_reaction_change <= r6_ghost_reg ? '0 : amc_pkg::sat_neg(mag_nh4);
            result.no2_reaction_change <= r6_ghost_reg ? '0 : amc_pkg::sat_neg(mag_no2);
            result.no3_reaction_change <= r6_ghost_reg ? '0 : amc_pkg::sat_pos(mag_no3);
            result.n2_reaction_change  <= r6_ghost_reg ? '0 : amc_pkg::sat_pos(mag_n2);
            result.net_growth_rate     <= r6_net_reg;
            result.last_cell_out       <= r6_last_reg;
        end
    end

endmodule

/* sim/amc_rate_checker.sv */
// checker for the anammox rate cell: tracks config writes, predicts each result word
module amc_rate_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cell_valid,
    input  logic                   cell_stall,
    input  amc_pkg::in_t           cell_word,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  amc_pkg::out_t          result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [amc_pkg::W-1:0]  cfg_data,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // local copy of the rate constants
    logic [amc_pkg::W-1:0] mu, k_nh4, k_o2, k_no2, inv_yield, maint, decay;
    amc_pkg::out_t         expected_words[$];

    assign pending = expected_words.size();

    // floor(num * 2^F / (num + other)), fallback on a zero denominator
    function automatic logic [63:0] monod(logic [63:0] num, logic [63:0] other,
                                          logic [63:0] fallback);
        logic [63:0] den;
        den = num + other;
        if (den == 0)
            return fallback;
        return (num << amc_pkg::F) / den;
    endfunction

    function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
        return (a * b) >> amc_pkg::F;
    endfunction

    function automatic logic [127:0] change(logic [127:0] coef, logic [127:0] rate,
                                            logic [127:0] dens);
        return (coef * rate * dens) >> (2 * amc_pkg::F);
    endfunction

    function automatic logic [amc_pkg::W-1:0] clamp_neg(logic [127:0] mag);
        if (mag > (128'd1 << (amc_pkg::W - 1)))
            return {1'b1, {(amc_pkg::W-1){1'b0}}};
        return amc_pkg::W'(0) - mag[amc_pkg::W-1:0];
    endfunction

    function automatic logic [amc_pkg::W-1:0] clamp_pos(logic [127:0] mag);
        if (mag > ((128'd1 << (amc_pkg::W - 1)) - 1))
            return {1'b0, {(amc_pkg::W-1){1'b1}}};
        return mag[amc_pkg::W-1:0];
    endfunction

    // expected result word for one grid cell
    function automatic amc_pkg::out_t predict_cell(amc_pkg::in_t c);
        logic [63:0]    one_q, inv_c, t_nh4, t_no2, t_inh, t_o2, rate, loss;
        amc_pkg::out_t  r;
        one_q = 64'd1 << amc_pkg::F;
        inv_c = (64'd100 * one_q + 64'd57) / 64'd114;
        t_nh4 = monod(c.nh4_concentration, k_nh4, 0);
        t_no2 = monod(c.no2_concentration, k_no2, 0);
        t_inh = monod(k_o2, c.o2_concentration, one_q);
        t_o2  = monod(c.o2_concentration, k_o2, 0);
        rate  = mul_q(mul_q(mul_q(mu, t_nh4), t_no2), t_inh);
        loss  = mul_q(maint, t_o2) + decay;
        if (c.ghost_cell) begin
            r.nh4_reaction_change = '0;
            r.no2_reaction_change = '0;
            r.no3_reaction_change = '0;
            r.n2_reaction_change  = '0;
        end else begin
            r.nh4_reaction_change = clamp_neg(change(inv_yield, rate, c.biomass_density));
            r.no2_reaction_change = clamp_neg(change(64'(inv_yield) + inv_c, rate,
                                                     c.biomass_density));
            r.no3_reaction_change = clamp_pos(change(inv_c, rate, c.biomass_density));
            r.n2_reaction_change  = clamp_pos(change(64'(inv_yield) * 2, rate,
                                                     c.biomass_density));
        end
        if (rate >= loss)
            r.net_growth_rate = clamp_pos(rate - loss);
        else
            r.net_growth_rate = clamp_neg(loss - rate);
        r.last_cell_out = c.last_cell;
        return r;
    endfunction

    task automatic report(string field, logic [amc_pkg::W-1:0] got,
                          logic [amc_pkg::W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // watch config writes, cell words and result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu        <= '0;
            k_nh4     <= '0;
            k_o2      <= '0;
            k_no2     <= '0;
            inv_yield <= amc_pkg::ONE;
            maint     <= '0;
            decay     <= '0;
        end else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    amc_pkg::CFG_MAX_GROWTH: mu        <= cfg_data;
                    amc_pkg::CFG_NH4_AFFIN:  k_nh4     <= cfg_data;
                    amc_pkg::CFG_O2_AFFIN:   k_o2      <= cfg_data;
                    amc_pkg::CFG_NO2_AFFIN:  k_no2     <= cfg_data;
                    amc_pkg::CFG_INV_YIELD:  inv_yield <= cfg_data;
                    amc_pkg::CFG_MAINT:      maint     <= cfg_data;
                    amc_pkg::CFG_DECAY:      decay     <= cfg_data;
                    default: ;
                endcase
            end
            if (cell_valid && !cell_stall)
                expected_words.push_back(predict_cell(cell_word));
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("unexpected result word at %0t", $realtime);
                    errors++;
                end else
                begin
                    amc_pkg::out_t e;
                    e = expected_words.pop_front();
                    if (result.nh4_reaction_change !== e.nh4_reaction_change)
                        report("nh4_reaction_change", result.nh4_reaction_change,
                               e.nh4_reaction_change);
                    if (result.no2_reaction_change !== e.no2_reaction_change)
                        report("no2_reaction_change", result.no2_reaction_change,
                               e.no2_reaction_change);
                    if (result.no3_reaction_change !== e.no3_reaction_change)
                        report("no3_reaction_change", result.no3_reaction_change,
                               e.no3_reaction_change);
                    if (result.n2_reaction_change !== e.n2_reaction_change)
                        report("n2_reaction_change", result.n2_reaction_change,
                               e.n2_reaction_change);
                    if (result.net_growth_rate !== e.net_growth_rate)
                        report("net_growth_rate", result.net_growth_rate,
                               e.net_growth_rate);
                    if (result.last_cell_out !== e.last_cell_out)
                        report("last_cell_out", amc_pkg::W'(result.last_cell_out),
                               amc_pkg::W'(e.last_cell_out));
                end
            end
        end
    end

    initial errors = 0;
endmodule

/* sim/tb_anammox_monod_rate_cell_top.sv */
// testbench top for the anammox rate cell: stimulus, config phases and verdict
module tb_anammox_monod_rate_cell_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_NONE   = 3'd7;
    localparam int         DRAIN      = 40;
    localparam int         CYCLE_CAP  = 400000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cell_valid = 1'b0;
    logic                   cell_stall;
    amc_pkg::in_t           cell_word = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    amc_pkg::out_t          result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [amc_pkg::W-1:0]  cfg_data = '0;
    int                     errors, pending;
    int                     idle_pct = 0, stall_pct = 0;
    int                     cycles = 0;

    anammox_monod_rate_cell_top dut (.*);

    amc_rate_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // run time limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // value spread over zero, full scale, values below 4.0, single bits and random bits
    function automatic logic [amc_pkg::W-1:0] pick_value();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return $urandom_range(32'h3_FFFF);
            4: return amc_pkg::W'(1) << $urandom_range(amc_pkg::W - 1);
            default: return $urandom >> $urandom_range(amc_pkg::W - 1);
        endcase
    endfunction

    task automatic send_word(amc_pkg::in_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_word  <= c;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [amc_pkg::W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // let the pipeline empty before touching the registers
    task automatic drain();
        cell_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_rates(logic [amc_pkg::W-1:0] v[7]);
        write_reg(amc_pkg::CFG_MAX_GROWTH, v[0]);
        write_reg(amc_pkg::CFG_NH4_AFFIN,  v[1]);
        write_reg(amc_pkg::CFG_O2_AFFIN,   v[2]);
        write_reg(amc_pkg::CFG_NO2_AFFIN,  v[3]);
        write_reg(amc_pkg::CFG_INV_YIELD,  v[4]);
        write_reg(amc_pkg::CFG_MAINT,      v[5]);
        write_reg(amc_pkg::CFG_DECAY,      v[6]);
        // out of range index, must be ignored
        write_reg(CFG_NONE, $urandom);
    endtask

    // edge cases: zeros, full scale, zero oxygen, ghost and last marks
    task automatic directed_words();
        amc_pkg::in_t c;
        c = '0;
        send_word(c);
        c = '1;
        send_word(c);
        c = {32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0, 1'b1};
        send_word(c);
        c = {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0};
        send_word(c);
        c = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0};
        send_word(c);
        c = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0002_0000, 1'b0, 1'b1};
        send_word(c);
        c = {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1};
        send_word(c);
        c = {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0};
        send_word(c);
    endtask

    initial
    begin
        logic [amc_pkg::W-1:0] rates[7];
        amc_pkg::in_t          c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        directed_words();

        // zero affinities, unit growth, yield and maintenance, decay 0.25
        drain();
        rates = '{32'h0001_0000, '0, '0, '0, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000};
        load_rates(rates);
        directed_words();

        // everything at full scale
        drain();
        rates = '{'1, '1, '1, '1, '1, '1, '1};
        load_rates(rates);
        directed_words();

        // random phases cycling through the idle and stall modes
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            foreach (rates[i])
                rates[i] = pick_value();
            load_rates(rates);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            for (int n = 0; n < 230; n++)
            begin
                c.nh4_concentration = pick_value();
                c.no2_concentration = pick_value();
                c.o2_concentration  = pick_value();
                c.biomass_density   = pick_value();
                c.ghost_cell        = ($urandom_range(9) == 0);
                c.last_cell         = ($urandom_range(15) == 0);
                send_word(c);
            end
        end

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
